// ===== src/alsr_pkg.sv =====
// Shared types, constants and register codes of the addressable LED serializer.
package alsr_pkg;

    localparam int DEF_PIXEL_DEPTH = 64;

    localparam int COLOUR_W    = 24;
    localparam int BITPOS_W    = 5;
    localparam int PHASE_W     = 8;
    localparam int PERIOD_W    = 9;
    localparam int HIGH_W      = 8;
    localparam int LATCH_W     = 16;
    localparam int PIXCNT_W    = 7;
    localparam int INDEX_W     = 8;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [BITPOS_W-1:0] COLOUR_MSB = 5'd23;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 9'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 9'd256;

    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 9'd20;
    localparam logic [HIGH_W-1:0]   RST_ONE_HIGH   = 8'd13;
    localparam logic [HIGH_W-1:0]   RST_ZERO_HIGH  = 8'd6;
    localparam logic [LATCH_W-1:0]  RST_LATCH      = 16'd1000;
    localparam logic [PIXCNT_W-1:0] RST_PIXELS     = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS     = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_START = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_LATCH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== src/alsr_ctrl.sv =====
// Controller state machine that sequences one item through capture, read and execute.
module alsr_ctrl
    import alsr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.read    = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                // The result register must be free before the state is updated.
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/alsr_dp.sv =====
// Datapath: settings, pixel memory, refresh counters and the result register.
module alsr_dp
    import alsr_pkg::*;
#(
    parameter int PIXEL_DEPTH = DEF_PIXEL_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [OP_W-1:0]        i_op,
    input  logic [INDEX_W-1:0]     i_pixel_index,
    input  logic [COLOUR_W-1:0]    i_colour,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam int PW = $clog2(PIXEL_DEPTH + 1);
    localparam logic [PERIOD_W-1:0] DEPTH_CNT = PERIOD_W'(PIXEL_DEPTH);

    // Settings.
    logic [PERIOD_W-1:0] r_cfg_period;
    logic [HIGH_W-1:0]   r_cfg_one;
    logic [HIGH_W-1:0]   r_cfg_zero;
    logic [LATCH_W-1:0]  r_cfg_latch;
    logic [PIXCNT_W-1:0] r_cfg_pixels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= RST_BIT_PERIOD;
            r_cfg_one    <= RST_ONE_HIGH;
            r_cfg_zero   <= RST_ZERO_HIGH;
            r_cfg_latch  <= RST_LATCH;
            r_cfg_pixels <= RST_PIXELS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIT_PERIOD: r_cfg_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_ONE_HIGH:   r_cfg_one    <= i_cfg_data[HIGH_W-1:0];
                CFG_ZERO_HIGH:  r_cfg_zero   <= i_cfg_data[HIGH_W-1:0];
                CFG_LATCH:      r_cfg_latch  <= i_cfg_data[LATCH_W-1:0];
                CFG_PIXELS:     r_cfg_pixels <= i_cfg_data[PIXCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured item.
    t_op                 r_op;
    logic [INDEX_W-1:0]  r_index;
    logic [COLOUR_W-1:0] r_colour;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_index  <= i_pixel_index;
            r_colour <= i_colour;
        end
    end

    // Refresh state.
    t_mode               r_mode;
    logic [PW-1:0]       r_pos;
    logic [BITPOS_W-1:0] r_bitpos;
    logic [PHASE_W-1:0]  r_phase;
    logic [LATCH_W-1:0]  r_latch;

    // Pixel memory. Entries without their valid bit read as the fill colour,
    // so a fill or reset sets the fill colour and clears the valid bits, leaving the entries untouched.
    logic [COLOUR_W-1:0] r_mem [PIXEL_DEPTH];
    logic [PIXEL_DEPTH-1:0] r_valid;
    logic [COLOUR_W-1:0] r_fill;
    logic [COLOUR_W-1:0] r_rd_data;
    logic                r_rd_hit;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                busy;
    logic                index_ok;
    logic                mem_we;
    logic                fill_en;

    assign busy     = (r_mode != MODE_IDLE);
    assign index_ok = ({1'b0, r_index} < DEPTH_CNT);
    assign wr_addr  = r_index[AW-1:0];
    assign mem_we   = i_cmd.exec && (r_op == OP_WRITE) && !busy && index_ok;
    assign fill_en  = i_cmd.exec && (r_op == OP_FILL) && !busy;
    assign rd_addr  = ((r_op == OP_START) && !busy) ? '0 : r_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_colour;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fill   <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_rd_hit <= r_valid[rd_addr];
            end
            if (fill_en) begin
                r_valid <= '0;
                r_fill  <= r_colour;
            end else if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Clamped settings.
    logic [PERIOD_W-1:0] period_now;
    logic [PERIOD_W-1:0] pixels_now;

    always_comb begin
        if (r_cfg_period < PERIOD_MIN) begin
            period_now = PERIOD_MIN;
        end else if (r_cfg_period > PERIOD_MAX) begin
            period_now = PERIOD_MAX;
        end else begin
            period_now = r_cfg_period;
        end
        if (r_cfg_pixels == '0) begin
            pixels_now = PERIOD_W'(1);
        end else if (PERIOD_W'(r_cfg_pixels) > DEPTH_CNT) begin
            pixels_now = DEPTH_CNT;
        end else begin
            pixels_now = PERIOD_W'(r_cfg_pixels);
        end
    end

    // Line level and next state.
    logic                start_ok;
    logic                lvl_send;
    logic [PHASE_W-1:0]  lvl_phase;
    logic [BITPOS_W-1:0] lvl_bitpos;
    logic [COLOUR_W-1:0] cur_colour;
    logic [BITPOS_W-1:0] bit_sel;
    logic [HIGH_W-1:0]   high_ticks;
    logic                level;
    logic                dropped;
    logic [LATCH_W-1:0]  latch_dec;
    t_mode               n_mode;
    logic [PW-1:0]       n_pos;
    logic [BITPOS_W-1:0] n_bitpos;
    logic [PHASE_W-1:0]  n_phase;
    logic [LATCH_W-1:0]  n_latch;

    always_comb begin
        start_ok   = (r_op == OP_START) && !busy;
        lvl_send   = start_ok || (r_mode == MODE_SEND);
        lvl_phase  = start_ok ? '0 : r_phase;
        lvl_bitpos = start_ok ? '0 : r_bitpos;
        cur_colour = r_rd_hit ? r_rd_data : r_fill;
        bit_sel    = COLOUR_MSB - lvl_bitpos;
        high_ticks = cur_colour[bit_sel] ? r_cfg_one : r_cfg_zero;
        level      = lvl_send && (lvl_phase < high_ticks);
        latch_dec  = (r_latch != '0) ? (r_latch - LATCH_W'(1)) : r_latch;

        n_mode   = r_mode;
        n_pos    = r_pos;
        n_bitpos = r_bitpos;
        n_phase  = r_phase;
        n_latch  = r_latch;
        dropped  = 1'b0;

        case (r_op)
            OP_TICK: begin
                if (r_mode == MODE_SEND) begin
                    if ((PERIOD_W'(r_phase) + PERIOD_W'(1)) >= period_now) begin
                        n_phase = '0;
                        if (r_bitpos == COLOUR_MSB) begin
                            n_bitpos = '0;
                            n_pos    = r_pos + PW'(1);
                            if ((PERIOD_W'(r_pos) + PERIOD_W'(1)) >= pixels_now) begin
                                n_latch = r_cfg_latch;
                                n_mode  = (r_cfg_latch == '0) ? MODE_IDLE : MODE_LATCH;
                            end
                        end else begin
                            n_bitpos = r_bitpos + BITPOS_W'(1);
                        end
                    end else begin
                        n_phase = r_phase + PHASE_W'(1);
                    end
                end else if (r_mode == MODE_LATCH) begin
                    n_latch = latch_dec;
                    if (latch_dec == '0) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            OP_WRITE: begin
                dropped = busy || !index_ok;
            end
            OP_FILL: begin
                dropped = busy;
            end
            OP_START: begin
                dropped = busy;
                if (!busy) begin
                    n_mode   = MODE_SEND;
                    n_pos    = '0;
                    n_bitpos = '0;
                    n_phase  = '0;
                    n_latch  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_bitpos <= '0;
            r_phase  <= '0;
            r_latch  <= '0;
        end else if (i_cmd.exec) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_bitpos <= n_bitpos;
            r_phase  <= n_phase;
            r_latch  <= n_latch;
        end
    end

    // Result register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {5'b0, dropped, (n_mode != MODE_IDLE), level};
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

// ===== src/addressable_led_serializer.sv =====
// Top level of the addressable LED serializer: controller, datapath and checks.
//
// Channel   | Direction | Payload
// ----------+-----------+----------------------------------------------------
// s_axis    | in        | tuser: operation[1:0]; tdata: pixel_index, colour
// m_axis    | out       | tdata: line_level, busy_res, ignored
// cfg       | in        | write enable, register index, write data
//
// Every item, a timer tick included, goes through capture, memory read and
// execute, and the pixel memory is read in its own step before execute. A
// finished result waits in an output register while the next item is captured
// and read; the execute step holds while the result register is still full.
// Reset is synchronous and active low; it clears the pixel store at once
// through per-entry valid bits, with no clearing pass.
module addressable_led_serializer
    import alsr_pkg::*;
#(
    parameter int PIXEL_DEPTH = DEF_PIXEL_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: pixel_index[7:0], colour[31:8]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: line_level[0], busy_res[1], ignored[2], zero fill[7:3]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    alsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    alsr_dp #(
        .PIXEL_DEPTH (PIXEL_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_s_axis_tuser),
        .i_pixel_index (i_s_axis_tdata[INDEX_W-1:0]),
        .i_colour      (i_s_axis_tdata[INDEX_W+COLOUR_W-1:INDEX_W]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // An accepted transfer is read from memory in the very next cycle.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> cmd.read)
        else $error("accepted item was not followed by a memory read");

    // The read step is followed by the execute step.
    a_read_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.read |=> !cmd.read && !o_s_axis_tready)
        else $error("read step not followed by execute step");

    // Execution never overwrites a result that has not been taken.
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> stat.out_free)
        else $error("result register overwritten");

    // A new result appears only after an execute step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(cmd.exec))
        else $error("result shown without an execute step");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the addressable LED serializer, with its own line predictor.
`timescale 1ns / 1ps

module tb_top
    import alsr_pkg::*;
();

    localparam int STRIP_LEN     = DEF_PIXEL_DEPTH;
    localparam int ITEM_TARGET   = 1850;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int MAX_REPORTS   = 10;

    // One request to the serializer, as it travels on the slave side.
    typedef struct packed {
        t_op                 op;
        logic [INDEX_W-1:0]  index;
        logic [COLOUR_W-1:0] colour;
    } t_strip_req;

    // One predicted response: the line level, the busy flag and the drop flag.
    typedef struct packed {
        logic line_level;
        logic busy;
        logic dropped;
    } t_line_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata: pixel_index[7:0], colour[31:8]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // tuser: operation[1:0]
    logic [OP_W-1:0]        i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata: line_level[0], busy_res[1], ignored[2], zero fill[7:3]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    addressable_led_serializer #(
        .PIXEL_DEPTH(STRIP_LEN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Requests waiting for the driver, and responses the predictor has worked out.
    t_strip_req   strip_reqs[$];
    t_line_result line_expected[$];

    // Bookkeeping shared by the stimulus, the driver and the monitor.
    int items_issued  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    bit sender_gaps   = 1'b1;
    bit receiver_stalls = 1'b1;

    // ------------------------------------------------------------------
    // Line predictor. It keeps a private copy of the pixel store, the
    // transmit position and the register values, and is advanced once for
    // every request the block accepts.
    // ------------------------------------------------------------------
    logic [COLOUR_W-1:0] strip_colours [STRIP_LEN];
    logic [PIXCNT_W-1:0] send_pixel;
    logic [BITPOS_W-1:0] send_bit;
    logic [PHASE_W-1:0]  bit_phase;
    logic [LATCH_W-1:0]  latch_left;
    t_mode               line_mode;

    logic [PERIOD_W-1:0] reg_period;
    logic [HIGH_W-1:0]   reg_one_high;
    logic [HIGH_W-1:0]   reg_zero_high;
    logic [LATCH_W-1:0]  reg_latch;
    logic [PIXCNT_W-1:0] reg_pixels;

    // The bit period is clamped into the range the counter can handle.
    function automatic int period_clamped();
        if (reg_period < PERIOD_MIN) return int'(PERIOD_MIN);
        if (reg_period > PERIOD_MAX) return int'(PERIOD_MAX);
        return int'(reg_period);
    endfunction

    // A pixel count of zero still sends one pixel; too large a count sends them all.
    function automatic int pixels_clamped();
        if (reg_pixels == '0) return 1;
        if (int'(reg_pixels) > STRIP_LEN) return STRIP_LEN;
        return int'(reg_pixels);
    endfunction

    // Level the line drives on the next tick. The colour goes out MSB first and
    // the line is high while the phase is below the high time of the bit.
    function automatic logic line_level_now();
        logic [COLOUR_W-1:0] colour;
        logic                bit_value;
        if (line_mode != MODE_SEND) return 1'b0;
        colour = (int'(send_pixel) < STRIP_LEN) ? strip_colours[send_pixel] : '0;
        bit_value = colour[int'(COLOUR_MSB) - int'(send_bit)];
        return int'(bit_phase) < (bit_value ? int'(reg_one_high) : int'(reg_zero_high));
    endfunction

    // One timer tick: step the phase, the bit, the pixel, then the latch time.
    // A phase already past a shortened period ends the bit on this tick, and a
    // pixel count lowered below the current pixel ends the refresh after it.
    function automatic void advance_line();
        if (line_mode == MODE_SEND) begin
            if (int'(bit_phase) + 1 >= period_clamped()) begin
                bit_phase = '0;
                if (send_bit == COLOUR_MSB) begin
                    send_bit   = '0;
                    send_pixel = send_pixel + 1'b1;
                    if (int'(send_pixel) >= pixels_clamped()) begin
                        latch_left = reg_latch;
                        line_mode  = (reg_latch == '0) ? MODE_IDLE : MODE_LATCH;
                    end
                end else begin
                    send_bit = send_bit + 1'b1;
                end
            end else begin
                bit_phase = bit_phase + 1'b1;
            end
        end else if (line_mode == MODE_LATCH) begin
            if (latch_left != '0) latch_left = latch_left - 1'b1;
            if (latch_left == '0) line_mode = MODE_IDLE;
        end
    endfunction

    // Apply one accepted request and return the response the block must give.
    function automatic t_line_result predict_line(t_strip_req req);
        t_line_result res;
        res.dropped = 1'b0;
        if (req.op == OP_TICK) begin
            res.line_level = line_level_now();
            advance_line();
        end else begin
            if (line_mode != MODE_IDLE) begin
                // Writes, fills and starts are refused during a refresh.
                res.dropped = 1'b1;
            end else begin
                case (req.op)
                    OP_WRITE: begin
                        if (int'(req.index) < STRIP_LEN) strip_colours[req.index] = req.colour;
                        else res.dropped = 1'b1;
                    end
                    OP_FILL: begin
                        foreach (strip_colours[i]) strip_colours[i] = req.colour;
                    end
                    OP_START: begin
                        send_pixel = '0;
                        send_bit   = '0;
                        bit_phase  = '0;
                        latch_left = '0;
                        line_mode  = MODE_SEND;
                    end
                    default: ;
                endcase
            end
            res.line_level = line_level_now();
        end
        res.busy = (line_mode != MODE_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Gap or stall length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [COLOUR_W-1:0] rand_colour();
        logic [31:0] word;
        word = $urandom;
        return word[COLOUR_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        logic [31:0] word;
        word = $urandom;
        return word[INDEX_W-1:0];
    endfunction

    // High time: mostly around the bit period, sometimes zero or the maximum.
    function automatic int pick_high_ticks(int period);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return 255;
        return $urandom_range(0, period + 1);
    endfunction

    task automatic queue_req(input t_op op, input logic [INDEX_W-1:0] index,
                             input logic [COLOUR_W-1:0] colour);
        t_strip_req req;
        req.op     = op;
        req.index  = index;
        req.colour = colour;
        strip_reqs.push_back(req);
        items_issued++;
    endtask

    // Every request produces exactly one response, so the block has nothing
    // in flight once the response count has caught up with the request count.
    task automatic wait_drained();
        while (results_seen < items_issued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: one cycle with the write enable high. The predictor's
    // copy is updated at the same point in the request order as the block's.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        case (index)
            CFG_BIT_PERIOD: reg_period    = value[PERIOD_W-1:0];
            CFG_ONE_HIGH:   reg_one_high  = value[HIGH_W-1:0];
            CFG_ZERO_HIGH:  reg_zero_high = value[HIGH_W-1:0];
            CFG_LATCH:      reg_latch     = value[LATCH_W-1:0];
            CFG_PIXELS:     reg_pixels    = value[PIXCNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_line_regs(input int period, input int one_high, input int zero_high,
                                 input int latch, input int pixels);
        write_reg(CFG_BIT_PERIOD, period);
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ZERO_HIGH, zero_high);
        write_reg(CFG_LATCH, latch);
        write_reg(CFG_PIXELS, pixels);
    endtask

    // ------------------------------------------------------------------
    // Slave-side driver. A new request is put on the bus only once the
    // previous transfer has completed, after an optional random gap. The
    // request on the bus is kept in bus_req so the predictor sees exactly
    // what the block took.
    // ------------------------------------------------------------------
    t_strip_req bus_req;
    int         send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                line_expected.push_back(predict_line(bus_req));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (strip_reqs.size() > 0) begin
                    bus_req = strip_reqs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= bus_req.op;
                    i_s_axis_tdata  <= {bus_req.colour, bus_req.index};
                    send_gap = sender_gaps ? pick_gap() : 0;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Master-side monitor and receiver. Each transfer is checked against the
    // oldest prediction. tready drops at random, and once, in the middle of
    // the run, it stays low for a long stretch while the driver still has
    // requests to offer, so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    t_line_result want;
    int           hold_left = 0;
    bit           long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (line_expected.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("response %0d arrived with no request pending: tdata %02h",
                                 results_seen, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = line_expected.pop_front();
                    if (o_m_axis_tdata[0] !== want.line_level || o_m_axis_tdata[1] !== want.busy
                        || o_m_axis_tdata[2] !== want.dropped
                        || o_m_axis_tdata[OUT_TDATA_W-1:3] !== '0) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"response %0d: expected level %0b busy %0b ignored %0b,",
                                      " got level %0b busy %0b ignored %0b (tdata %02h)"},
                                     results_seen, want.line_level, want.busy, want.dropped,
                                     o_m_axis_tdata[0], o_m_axis_tdata[1], o_m_axis_tdata[2],
                                     o_m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 200 && strip_reqs.size() >= 10) begin
                long_hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                hold_left = pick_gap();
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer or register write
    // means the block has hung.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: reset, a directed part, then random phases. Between
    // phases the sender pauses until every response is in, then the
    // registers are rewritten; a refresh may still be running at that point,
    // which exercises the registers taking effect mid-refresh.
    // ------------------------------------------------------------------
    initial begin
        int roll;
        int period;
        int one_high;
        int zero_high;
        int latch;
        int pixels;
        int count;

        foreach (strip_colours[i]) strip_colours[i] = '0;
        send_pixel    = '0;
        send_bit      = '0;
        bit_phase     = '0;
        latch_left    = '0;
        line_mode     = MODE_IDLE;
        reg_period    = RST_BIT_PERIOD;
        reg_one_high  = RST_ONE_HIGH;
        reg_zero_high = RST_ZERO_HIGH;
        reg_latch     = RST_LATCH;
        reg_pixels    = RST_PIXELS;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values: a tick while idle,
        // writes just past and far past the end of the store, writes at both
        // ends, a fill, a start, and every request kind while busy.
        queue_req(OP_TICK, 8'd0, 24'd0);
        queue_req(OP_FILL, 8'd0, 24'h5AC3A5);
        queue_req(OP_WRITE, 8'hFF, 24'hFFFFFF);
        queue_req(OP_WRITE, 8'd64, 24'h123456);
        queue_req(OP_WRITE, 8'd0, 24'hFFFFFF);
        queue_req(OP_WRITE, 8'd63, 24'h000000);
        queue_req(OP_START, 8'd0, 24'd0);
        queue_req(OP_WRITE, 8'd2, 24'hABCDEF);
        queue_req(OP_FILL, 8'd0, 24'h000000);
        queue_req(OP_START, 8'd0, 24'd0);
        repeat (3) queue_req(OP_TICK, rand_index(), rand_colour());
        wait_drained();

        // Mid-refresh change: a period below the minimum, a zero latch time,
        // a zero pixel count below the current pixel, a one-bit high time
        // past the period and a zero-bit high time of nothing. Pixel 0 is all
        // ones, so the refresh ends after 47 ticks straight into idle.
        set_line_regs(1, 255, 0, 0, 0);
        repeat (50) queue_req(OP_TICK, rand_index(), rand_colour());

        while (items_issued < ITEM_TARGET) begin
            wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // Slow settings at the top of the period, pixel and latch ranges.
                // The refresh cannot reach its latch time within such a short
                // phase, so the huge latch value never gets loaded.
                period    = $urandom_range(0, 1) ? 256 : 511;
                pixels    = $urandom_range(0, 1) ? 64 : 127;
                latch     = 65535;
                one_high  = $urandom_range(0, 255);
                zero_high = $urandom_range(0, 255);
                count     = $urandom_range(15, 30);
            end else begin
                period    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                        : $urandom_range(2, 5);
                one_high  = pick_high_ticks(period);
                zero_high = pick_high_ticks(period);
                latch     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                pixels    = $urandom_range(0, 3);
                count     = $urandom_range(20, 80);
            end
            set_line_regs(period, one_high, zero_high, latch, pixels);
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);

            // Mostly ticks, so refreshes run to the end; the rest loads pixels
            // and starts new refreshes, many of which land while busy.
            repeat (count) begin
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    queue_req(OP_TICK, rand_index(), rand_colour());
                end else if (roll < 82) begin
                    queue_req(OP_WRITE,
                              ($urandom_range(0, 6) == 0) ? 8'($urandom_range(64, 255))
                                                          : 8'($urandom_range(0, 63)),
                              rand_colour());
                end else if (roll < 87) begin
                    queue_req(OP_FILL, rand_index(), rand_colour());
                end else begin
                    queue_req(OP_START, rand_index(), rand_colour());
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && line_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
